[hw/rtl/rw_pkg.sv]
// rw_pkg: shared types and codes for the reorder window
// widths, request modes, status codes and the sequencer state type
// no dependencies
`default_nettype none

package rw_pkg;

  localparam int unsigned SEQ_W = 32;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STATUS_W = 3;

  // ring of parked tags, indexed by the low bits of the sequence number
  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned RING_AW = 5;

  localparam int unsigned DEF_WINDOW_SIZE = 32;

  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNRESERVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_UNRESERVE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd4;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_RETIRE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_USED,
    S_RESV,
    S_UNRS,
    S_OFFS,
    S_DRAIN
  } rw_state_t;

endpackage

`default_nettype wire

[hw/rtl/rw_if.sv]
// rw_req_if and rw_rsp_if: valid/ready channels of the reorder window
// depends on rw_pkg for field widths
`default_nettype none

interface rw_req_if import rw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SEQ_W-1:0]  seq;
  logic [TAG_W-1:0]  ctx_tag;

  modport source (output valid, mode, seq, ctx_tag, input ready);
  modport sink (input valid, mode, seq, ctx_tag, output ready);
endinterface

interface rw_rsp_if import rw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [SEQ_W-1:0]    out_seq;
  logic [TAG_W-1:0]    out_tag;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, kind, out_seq, out_tag, status, last, input ready);
  modport sink (input valid, kind, out_seq, out_tag, status, last, output ready);
endinterface

`default_nettype wire

[hw/rtl/reorder_window.sv]
// reorder_window: sequence number window with in-order retirement of completions
// depends on rw_pkg and the channel interfaces in rw_if.sv
// a request word is taken only in idle, then steps through S_USED and S_RESV, S_UNRS
//   or S_OFFS, which loads its first result word into the output register; S_DRAIN
//   retires each further word; a full output register stalls the check and drain steps,
//   and no new request is taken until idle; one shared 32-bit subtractor serves the checks
// reset: head and tail numbers cleared, all ring slots empty; tags need no reset
`default_nettype none

module reorder_window import rw_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = DEF_WINDOW_SIZE
) (
  input  logic      clk,
  input  logic      rst,
  rw_req_if.sink    req,
  rw_rsp_if.source  rsp
);

  localparam logic [SEQ_W-1:0] FULL_MARK = SEQ_W'(WINDOW_SIZE - 1);

  rw_state_t state, state_next;

  // captured request word
  logic [MODE_W-1:0] mode_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [TAG_W-1:0]  tag_r;

  // window state
  logic [SEQ_W-1:0]   head_seq, head_seq_next;
  logic [SEQ_W-1:0]   tail_seq, tail_seq_next;
  logic [SEQ_W-1:0]   used, used_next;
  logic [RING_AW:0]   rem, rem_next;
  logic [RING_DEPTH-1:0] slot_valid;
  logic [TAG_W-1:0]   slot_tag [RING_DEPTH];

  // output register
  logic                out_valid;
  logic                out_kind;
  logic [SEQ_W-1:0]    out_seq_r;
  logic [TAG_W-1:0]    out_tag_r;
  logic [STATUS_W-1:0] out_status;
  logic                out_last;

  // shared subtractor
  logic [SEQ_W-1:0] alu_a, alu_b, alu_diff;

  logic [RING_AW-1:0] seq_idx, head_idx, head_idx_inc;
  logic               out_free;
  logic               cont;
  logic               outside, occupied, ahead, first_retire;

  logic                emit;
  logic                e_kind;
  logic [SEQ_W-1:0]    e_seq;
  logic [TAG_W-1:0]    e_tag;
  logic [STATUS_W-1:0] e_status;
  logic                e_last;

  logic               vset_en, vclr_en;
  logic [RING_AW-1:0] vset_idx, vclr_idx;

  assign seq_idx      = seq_r[RING_AW-1:0];
  assign head_idx     = head_seq[RING_AW-1:0];
  assign head_idx_inc = head_idx + RING_AW'(1);
  assign out_free     = !out_valid || rsp.ready;

  // operand select for the subtractor by step
  always_comb begin
    case (state)
      S_UNRS: begin
        alu_a = tail_seq;
        alu_b = seq_r;
      end
      S_OFFS: begin
        alu_a = seq_r;
        alu_b = head_seq;
      end
      default: begin
        alu_a = tail_seq;
        alu_b = head_seq;
      end
    endcase
  end
  assign alu_diff = alu_a - alu_b;

  // insert decisions and retirement continuation
  assign outside      = alu_diff >= used;
  assign occupied     = slot_valid[seq_idx];
  assign ahead        = alu_diff != '0;
  assign first_retire = !outside && !occupied && !ahead;
  assign cont         = (rem > (RING_AW + 1)'(1)) && slot_valid[head_idx_inc];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_USED;
      end
      S_USED: begin
        case (mode_r)
          MODE_RESERVE:   state_next = S_RESV;
          MODE_UNRESERVE: state_next = S_UNRS;
          MODE_INSERT:    state_next = S_OFFS;
          default:        state_next = S_IDLE;
        endcase
      end
      S_RESV, S_UNRS: begin
        if (out_free) state_next = S_IDLE;
      end
      S_OFFS: begin
        if (out_free) state_next = (first_retire && cont) ? S_DRAIN : S_IDLE;
      end
      S_DRAIN: begin
        if (out_free && !cont) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // result words and window updates
  always_comb begin
    emit          = 1'b0;
    e_kind        = KIND_ACK;
    e_seq         = seq_r;
    e_tag         = '0;
    e_status      = ST_OK;
    e_last        = 1'b1;
    head_seq_next = head_seq;
    tail_seq_next = tail_seq;
    used_next     = used;
    rem_next      = rem;
    vset_en       = 1'b0;
    vset_idx      = seq_idx;
    vclr_en       = 1'b0;
    vclr_idx      = seq_idx;
    case (state)
      S_USED: begin
        used_next = alu_diff;
        rem_next  = alu_diff[RING_AW:0];
      end
      S_RESV: begin
        emit = 1'b1;
        if (used >= FULL_MARK) begin
          e_status = ST_FULL;
          e_seq    = '0;
        end else begin
          e_seq = tail_seq;
          if (out_free) tail_seq_next = tail_seq + SEQ_W'(1);
        end
      end
      S_UNRS: begin
        emit = 1'b1;
        if (used == '0 || alu_diff != SEQ_W'(1)) begin
          e_status = ST_BAD_UNRESERVE;
        end else if (out_free) begin
          tail_seq_next = seq_r;
          vclr_en       = 1'b1;
        end
      end
      S_OFFS: begin
        emit = 1'b1;
        if (outside) begin
          e_status = ST_OUTSIDE;
        end else if (occupied) begin
          e_status = ST_OCCUPIED;
        end else if (ahead) begin
          vset_en = out_free;
        end else begin
          e_kind = KIND_RETIRE;
          e_seq  = head_seq;
          e_tag  = tag_r;
          e_last = !cont;
          if (out_free) begin
            head_seq_next = head_seq + SEQ_W'(1);
            rem_next      = rem - (RING_AW + 1)'(1);
          end
        end
      end
      S_DRAIN: begin
        emit   = 1'b1;
        e_kind = KIND_RETIRE;
        e_seq  = head_seq;
        e_tag  = slot_tag[head_idx];
        e_last = !cont;
        if (out_free) begin
          head_seq_next = head_seq + SEQ_W'(1);
          rem_next      = rem - (RING_AW + 1)'(1);
          vclr_en       = 1'b1;
          vclr_idx      = head_idx;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_seq   <= '0;
      tail_seq   <= '0;
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      head_seq <= head_seq_next;
      tail_seq <= tail_seq_next;
      if (vset_en) slot_valid[vset_idx] <= 1'b1;
      if (vclr_en) slot_valid[vclr_idx] <= 1'b0;
      if (emit && out_free) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      mode_r <= req.mode;
      seq_r  <= req.seq;
      tag_r  <= req.ctx_tag;
    end
    used <= used_next;
    rem  <= rem_next;
    if (vset_en) slot_tag[vset_idx] <= tag_r;
    if (emit && out_free) begin
      out_kind   <= e_kind;
      out_seq_r  <= e_seq;
      out_tag_r  <= e_tag;
      out_status <= e_status;
      out_last   <= e_last;
    end
  end

  // channel ports
  assign req.ready   = state == S_IDLE;
  assign rsp.valid   = out_valid;
  assign rsp.kind    = out_kind;
  assign rsp.out_seq = out_seq_r;
  assign rsp.out_tag = out_tag_r;
  assign rsp.status  = out_status;
  assign rsp.last    = out_last;

endmodule

`default_nettype wire
